// ----- rtl/ipsp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ipsp_pkg;

  // record field sizes
  localparam int ADDRESS_BYTES = 3;
  localparam int LENGTH_BYTES  = 2;
  localparam int HEADER_LEN    = 5;
  localparam int CNT_W         = 3;

  localparam logic [23:0] EOF_MARK       = 24'h454F46;
  localparam logic [24:0] ADDR_SPACE     = 25'h1000000;
  localparam logic [24:0] IMAGE_SIZE_RST = 25'h1000000;

  // result kinds
  localparam logic [2:0] KIND_WRITE  = 3'd0;
  localparam logic [2:0] KIND_FILL   = 3'd1;
  localparam logic [2:0] KIND_END    = 3'd2;
  localparam logic [2:0] KIND_BADHDR = 3'd3;
  localparam logic [2:0] KIND_RANGE  = 3'd4;

  // register map
  localparam logic REG_IMAGE_SIZE = 1'b0;

  // command queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int QC_W    = 3;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_OFFSET,
    PH_LENGTH,
    PH_COUNT,
    PH_FILL,
    PH_DATA
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [23:0] addr;
    logic [7:0]  data;
    logic [15:0] len;
  } result_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // "PATCH"
  function automatic logic [7:0] header_char(input logic [CNT_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h50;
      3'd1:    c = 8'h41;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h43;
      3'd4:    c = 8'h48;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ipsp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ipsp_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        patch_byte,
  input  wire logic              stream_start,
  input  wire logic [24:0]       image_size,
  input  wire ipsp_pkg::q_stat_t q_stat,
  output logic                   push,
  output ipsp_pkg::result_t      push_data
);

  localparam logic [ipsp_pkg::CNT_W-1:0] OFF_LAST =
    ipsp_pkg::CNT_W'(ipsp_pkg::ADDRESS_BYTES - 1);
  localparam logic [ipsp_pkg::CNT_W-1:0] LEN_LAST =
    ipsp_pkg::CNT_W'(ipsp_pkg::LENGTH_BYTES - 1);
  localparam logic [ipsp_pkg::CNT_W-1:0] HDR_LAST =
    ipsp_pkg::CNT_W'(ipsp_pkg::HEADER_LEN - 1);
  localparam logic [ipsp_pkg::CNT_W-1:0] HDR_END =
    ipsp_pkg::CNT_W'(ipsp_pkg::HEADER_LEN);

  ipsp_pkg::phase_t             phase_r, phase_nxt, ph_c;
  logic [ipsp_pkg::CNT_W-1:0]   cnt_r, cnt_nxt, cnt_c, cnt_inc;
  logic [23:0]                  off_r, off_nxt, off_c, off_shift;
  logic [15:0]                  rem_r, rem_nxt, rem_c, rem_shift, rem_dec, chk_len;
  logic [23:0]                  wa_r, wa_nxt, wa_c;
  logic                         stop_r, stop_nxt, stop_c;

  logic        acc;
  logic        hdr_bad, hdr_last, off_last, len_last, is_eof, beyond;
  logic [24:0] limit, rec_end;

  assign in_ready = !q_stat.full;
  assign acc      = in_valid && in_ready;

  // a start byte sees the parser as if just reset
  assign ph_c   = stream_start ? ipsp_pkg::PH_HEADER : phase_r;
  assign cnt_c  = stream_start ? '0 : cnt_r;
  assign off_c  = stream_start ? '0 : off_r;
  assign rem_c  = stream_start ? '0 : rem_r;
  assign wa_c   = stream_start ? '0 : wa_r;
  assign stop_c = stream_start ? 1'b0 : stop_r;

  assign cnt_inc   = cnt_c + 3'd1;
  assign off_shift = {off_c[15:0], patch_byte};
  assign rem_shift = {rem_c[7:0], patch_byte};
  assign rem_dec   = rem_c - 16'd1;

  assign hdr_bad  = (cnt_c >= HDR_END) || (patch_byte != ipsp_pkg::header_char(cnt_c));
  assign hdr_last = (cnt_c == HDR_LAST);
  assign off_last = (cnt_c == OFF_LAST);
  assign len_last = (cnt_c == LEN_LAST);
  assign is_eof   = (off_shift == ipsp_pkg::EOF_MARK);

  // record end check against image size capped at the 24-bit space
  assign limit   = image_size[24] ? ipsp_pkg::ADDR_SPACE : image_size;
  assign chk_len = (ph_c == ipsp_pkg::PH_LENGTH) ? rem_shift : rem_c;
  assign rec_end = {1'b0, off_c} + {9'b0, chk_len};
  assign beyond  = rec_end > limit;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      phase_nxt = ph_c;
      if (!stop_c) begin
        case (ph_c)
          ipsp_pkg::PH_HEADER: begin
            if (!hdr_bad && hdr_last) phase_nxt = ipsp_pkg::PH_OFFSET;
          end
          ipsp_pkg::PH_OFFSET: begin
            if (off_last && !is_eof) phase_nxt = ipsp_pkg::PH_LENGTH;
          end
          ipsp_pkg::PH_LENGTH: begin
            if (len_last) begin
              if (rem_shift == 16'd0) phase_nxt = ipsp_pkg::PH_COUNT;
              else if (!beyond)       phase_nxt = ipsp_pkg::PH_DATA;
            end
          end
          ipsp_pkg::PH_COUNT: begin
            if (len_last) phase_nxt = ipsp_pkg::PH_FILL;
          end
          ipsp_pkg::PH_FILL: begin
            if (!beyond) phase_nxt = ipsp_pkg::PH_OFFSET;
          end
          ipsp_pkg::PH_DATA: begin
            if (rem_dec == 16'd0) phase_nxt = ipsp_pkg::PH_OFFSET;
          end
          default: phase_nxt = ipsp_pkg::PH_HEADER;
        endcase
      end
    end
  end

  // datapath and commands
  always_comb begin
    cnt_nxt   = cnt_r;
    off_nxt   = off_r;
    rem_nxt   = rem_r;
    wa_nxt    = wa_r;
    stop_nxt  = stop_r;
    push      = 1'b0;
    push_data = '0;
    if (acc) begin
      cnt_nxt  = cnt_c;
      off_nxt  = off_c;
      rem_nxt  = rem_c;
      wa_nxt   = wa_c;
      stop_nxt = stop_c;
      if (!stop_c) begin
        case (ph_c)
          ipsp_pkg::PH_HEADER: begin
            if (hdr_bad) begin
              stop_nxt       = 1'b1;
              push           = 1'b1;
              push_data.kind = ipsp_pkg::KIND_BADHDR;
            end else if (hdr_last) begin
              cnt_nxt = '0;
              off_nxt = '0;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          ipsp_pkg::PH_OFFSET: begin
            off_nxt = off_shift;
            if (off_last) begin
              cnt_nxt = '0;
              if (is_eof) begin
                stop_nxt       = 1'b1;
                push           = 1'b1;
                push_data.kind = ipsp_pkg::KIND_END;
              end else begin
                rem_nxt = '0;
              end
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          ipsp_pkg::PH_LENGTH: begin
            rem_nxt = rem_shift;
            if (len_last) begin
              cnt_nxt = '0;
              if (rem_shift != 16'd0) begin
                if (beyond) begin
                  stop_nxt       = 1'b1;
                  push           = 1'b1;
                  push_data.kind = ipsp_pkg::KIND_RANGE;
                  push_data.addr = off_c;
                  push_data.len  = rem_shift;
                end else begin
                  wa_nxt = off_c;
                end
              end
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          ipsp_pkg::PH_COUNT: begin
            rem_nxt = rem_shift;
            cnt_nxt = len_last ? '0 : cnt_inc;
          end
          ipsp_pkg::PH_FILL: begin
            push           = 1'b1;
            push_data.addr = off_c;
            push_data.data = patch_byte;
            push_data.len  = rem_c;
            if (beyond) begin
              stop_nxt       = 1'b1;
              push_data.kind = ipsp_pkg::KIND_RANGE;
            end else begin
              push_data.kind = ipsp_pkg::KIND_FILL;
              cnt_nxt        = '0;
              off_nxt        = '0;
              rem_nxt        = '0;
            end
          end
          ipsp_pkg::PH_DATA: begin
            push           = 1'b1;
            push_data.kind = ipsp_pkg::KIND_WRITE;
            push_data.addr = wa_c;
            push_data.data = patch_byte;
            push_data.len  = 16'd1;
            wa_nxt         = wa_c + 24'd1;
            rem_nxt        = rem_dec;
            if (rem_dec == 16'd0) begin
              cnt_nxt = '0;
              off_nxt = '0;
            end
          end
          default: cnt_nxt = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ipsp_pkg::PH_HEADER;
      cnt_r   <= '0;
      off_r   <= '0;
      rem_r   <= '0;
      wa_r    <= '0;
      stop_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      off_r   <= off_nxt;
      rem_r   <= rem_nxt;
      wa_r    <= wa_nxt;
      stop_r  <= stop_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ipsp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ipsp_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire ipsp_pkg::result_t push_data,
  input  wire logic              pop,
  output ipsp_pkg::result_t      pop_data,
  output ipsp_pkg::q_stat_t      q_stat
);

  ipsp_pkg::result_t             mem_r [ipsp_pkg::Q_DEPTH];
  logic [ipsp_pkg::Q_AW-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [ipsp_pkg::QC_W-1:0]     count_r, count_nxt;

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == ipsp_pkg::QC_W'(ipsp_pkg::Q_DEPTH));
  assign pop_data     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

// ----- rtl/ipsp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ipsp_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ipsp_pkg::q_stat_t q_stat,
  input  wire ipsp_pkg::result_t pop_data,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_result_kind,
  output logic [23:0]            out_target_address,
  output logic [7:0]             out_data_byte,
  output logic [15:0]            out_run_length
);

  logic              out_valid_r, out_valid_nxt;
  ipsp_pkg::result_t out_word_r;

  // reload whenever the output slot is free or being drained
  assign pop = !q_stat.empty && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop)            out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop) out_word_r <= pop_data;
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_word_r.kind;
  assign out_target_address = out_word_r.addr;
  assign out_data_byte      = out_word_r.data;
  assign out_run_length     = out_word_r.len;

endmodule

`default_nettype wire

// ----- rtl/ips_patch_stream_parser_unit.sv -----
// IPS patch stream parser.
// Input channel (in_valid/in_ready): one patch byte per word, with
// in_stream_start marking the first byte of a new patch; that word restarts
// the parser and is checked as the first header byte.
// Output channel (out_valid/out_ready): one command word per result:
// byte write, fill run, end reached, bad header or out of range.
// Throughput: one byte per cycle sustained while the queue is not full.
// Every byte is classified in the cycle it is accepted; a command is
// pushed into a 4-entry queue and an output register drains it.
// Path: a byte's command is written into a queue entry and then into the
// output register before it shows, and waits longer if the receiver stalls.
// Stall: while out_ready is low the queue fills; in_ready drops only once
// all four entries are taken. Bytes that give no command never wait on the
// output side except through a full queue.
// After an end or an error the parser stays stopped, swallowing bytes,
// until a word with in_stream_start.
// Reset (rst_n low, synchronous): parser goes to the header phase, queue
// and output register empty, image_size back to 16 MiB.
// APB register 0 (paddr 0): image_size, 25 bits; write it while idle.
`timescale 1ns / 1ps
`default_nettype none

module ips_patch_stream_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // patch bytes
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_patch_byte,
  input  wire logic        in_stream_start,
  // commands
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_result_kind,
  output logic [23:0]      out_target_address,
  output logic [7:0]       out_data_byte,
  output logic [15:0]      out_run_length,
  // APB register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [24:0]       image_size_r, image_size_nxt;
  logic              reg_sel;

  logic              push, pop;
  ipsp_pkg::result_t push_data, pop_data;
  ipsp_pkg::q_stat_t q_stat;

  // register file: only word 0 exists, byte offset ignored
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == ipsp_pkg::REG_IMAGE_SIZE);

  always_comb begin
    image_size_nxt = image_size_r;
    if (psel && penable && pwrite && reg_sel) image_size_nxt = pwdata[24:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) image_size_r <= ipsp_pkg::IMAGE_SIZE_RST;
    else        image_size_r <= image_size_nxt;
  end

  assign prdata = reg_sel ? {7'b0, image_size_r} : 32'b0;

  // front: byte parser
  ipsp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .patch_byte   (in_patch_byte),
    .stream_start (in_stream_start),
    .image_size   (image_size_r),
    .q_stat       (q_stat),
    .push         (push),
    .push_data    (push_data)
  );

  // command queue decoupling parser from the receiver
  ipsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // back: output register
  ipsp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_stat             (q_stat),
    .pop_data           (pop_data),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_kind    (out_result_kind),
    .out_target_address (out_target_address),
    .out_data_byte      (out_data_byte),
    .out_run_length     (out_run_length)
  );

endmodule

`default_nettype wire

// ----- rtl/ipsp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ipsp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_result_kind,
  input wire logic [23:0] out_target_address,
  input wire logic [7:0]  out_data_byte,
  input wire logic [15:0] out_run_length
);

  // output empties on reset
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind) &&
      $stable(out_target_address) && $stable(out_data_byte) && $stable(out_run_length))
    else $error("stalled output changed");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_kind <= ipsp_pkg::KIND_RANGE)
    else $error("unknown result kind");

  a_write_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == ipsp_pkg::KIND_WRITE |-> out_run_length == 16'd1)
    else $error("byte write with run length other than one");

  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == ipsp_pkg::KIND_END ||
                  out_result_kind == ipsp_pkg::KIND_BADHDR)
    |-> out_target_address == 24'd0 && out_data_byte == 8'd0 && out_run_length == 16'd0)
    else $error("end or header error carries nonzero fields");

endmodule

bind ips_patch_stream_parser_unit ipsp_checker u_ipsp_checker (.*);

`default_nettype wire
